// File: hdl/erm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erm_pkg: shared definitions for the echo range median filter
// Field widths, register indexes, reset values, queue entry and status types.
// ----------------------------------------------------------------------------
package erm_pkg;

    localparam int SENSORS_DEF = 4;
    localparam int WINDOW_DEF  = 5;

    localparam int DIST_W  = 16;
    localparam int SCALE_W = 12;
    localparam int DUR_W   = 24;
    localparam int SID_W   = 2;
    localparam int FRAC_W  = 10;
    localparam int PROD_W  = DUR_W + SCALE_W;
    localparam int RAW_W   = PROD_W - FRAC_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 2'd2;

    localparam logic [DIST_W-1:0]  MIN_DIST_RST    = 16'd128;
    localparam logic [DIST_W-1:0]  MAX_DIST_RST    = 16'd25600;
    localparam logic [SCALE_W-1:0] SPEED_SCALE_RST = 12'd1114;

    // request codes
    localparam logic REQ_ECHO = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam int QUEUE_DEPTH = 4;

    // one classified item as it sits in the queue
    typedef struct packed {
        logic             req_type;
        logic [SID_W-1:0] sensor_id;
        logic             sensor_ok;
        logic [RAW_W-1:0] raw;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic [DIST_W-1:0] min_dist;
        logic [DIST_W-1:0] max_dist;
    } window_t;

endpackage
`default_nettype wire

// File: hdl/echo_range_median_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// echo_range_median_filter: ultrasonic echo distance filter, median of WINDOW
// Converts echo widths to distances and keeps a median-filtered value per sensor.
// ----------------------------------------------------------------------------
// An echo transfer (req_type 0) scales the echo width by speed_scale (Q2.10) into a
// distance in 1/64 cm; a distance inside [min, max] enters the sensor's ring and the
// held value becomes the ring median (reset zeros count), an out-of-window distance
// keeps the held value or zeroes it if it is itself out of window; either way the
// sensor is marked fresh. A read transfer (req_type 1) returns one result: the held
// distance with valid_res 1 once per fresh update, else 0/0. Echoes give no result.
// Transfers land in a 4-entry queue; the back end takes a read at the queue pop, an
// in-window echo through queue pop with ring row fetch, row update, compare matrix
// and rank select, and an out-of-window echo through pop and held check, so reads
// sustain one per cycle while the result register is free, and no new item is taken
// until an echo is through, set by the back-end sequencer and its single ring row
// port. A read passes the queue slot and then the result register before m_valid
// rises. No clearing pass: ring rows carry valid bits cleared at reset.
// Configuration writes take effect on the next cycle and must occur while idle.
// ----------------------------------------------------------------------------
module echo_range_median_filter #(
    parameter int SENSORS = erm_pkg::SENSORS_DEF,
    parameter int WINDOW  = erm_pkg::WINDOW_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [erm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [erm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [erm_pkg::SID_W-1:0]         s_sensor_id,
    input  logic [erm_pkg::DUR_W-1:0]         s_echo_width,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [erm_pkg::DIST_W-1:0]        m_distance,
    output logic                              m_valid_res
);

    // configuration registers
    logic [erm_pkg::DIST_W-1:0]  min_dist_reg;
    logic [erm_pkg::DIST_W-1:0]  max_dist_reg;
    logic [erm_pkg::SCALE_W-1:0] speed_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_dist_reg    <= erm_pkg::MIN_DIST_RST;
            max_dist_reg    <= erm_pkg::MAX_DIST_RST;
            speed_scale_reg <= erm_pkg::SPEED_SCALE_RST;
        end else if (cfg_we) begin
            // unknown indexes are dropped
            unique case (cfg_index)
                erm_pkg::CFG_MIN_DIST:    min_dist_reg    <= cfg_wdata;
                erm_pkg::CFG_MAX_DIST:    max_dist_reg    <= cfg_wdata;
                erm_pkg::CFG_SPEED_SCALE: speed_scale_reg <= cfg_wdata[erm_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    erm_pkg::window_t   win;
    erm_pkg::item_t     push_item;
    erm_pkg::item_t     head;
    erm_pkg::q_status_t q_status;
    logic               push;
    logic               pop;
    logic [$clog2(erm_pkg::QUEUE_DEPTH + 1)-1:0] q_level;

    assign win.min_dist = min_dist_reg;
    assign win.max_dist = max_dist_reg;

    // front: accept, scale, classify
    erm_front #(
        .SENSORS (SENSORS)
    ) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_sensor_id   (s_sensor_id),
        .s_echo_width  (s_echo_width),
        .speed_scale   (speed_scale_reg),
        .q_status      (q_status),
        .push          (push),
        .push_item     (push_item)
    );

    // decoupling queue
    erm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status),
        .level     (q_level)
    );

    // back: ring update, median, result register
    erm_back #(
        .SENSORS (SENSORS),
        .WINDOW  (WINDOW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .win         (win),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_distance  (m_distance),
        .m_valid_res (m_valid_res)
    );

`ifndef SYNTH
    // a stale read always reports zero distance
    a_stale_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_distance == '0)
        else $error("stale read returned nonzero distance");

    // queue never overfills
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= ($clog2(erm_pkg::QUEUE_DEPTH + 1))'(erm_pkg::QUEUE_DEPTH))
        else $error("queue level beyond depth");

    // backpressure only when the queue is full
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_level == ($clog2(erm_pkg::QUEUE_DEPTH + 1))'(erm_pkg::QUEUE_DEPTH))
        else $error("input stalled with room in queue");

    // no pop from an empty queue
    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// File: hdl/erm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erm_queue: item queue between front and back
// Small register FIFO holding classified items.
// ----------------------------------------------------------------------------
module erm_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  erm_pkg::item_t      push_item,
    input  logic                pop,
    output erm_pkg::item_t      head,
    output erm_pkg::q_status_t  status,
    output logic [$clog2(erm_pkg::QUEUE_DEPTH + 1)-1:0] level
);

    localparam int PTR_W = (erm_pkg::QUEUE_DEPTH > 1) ? $clog2(erm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(erm_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(erm_pkg::QUEUE_DEPTH - 1);

    erm_pkg::item_t   slot_reg [erm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(erm_pkg::QUEUE_DEPTH));
    assign level        = count_reg;

endmodule
`default_nettype wire

// File: hdl/erm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erm_front: input acceptance and classification
// Checks the sensor index and scales the echo width to a raw distance.
// ----------------------------------------------------------------------------
module erm_front #(
    parameter int SENSORS = erm_pkg::SENSORS_DEF
) (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [erm_pkg::SID_W-1:0]     s_sensor_id,
    input  logic [erm_pkg::DUR_W-1:0]     s_echo_width,
    input  logic [erm_pkg::SCALE_W-1:0]   speed_scale,
    input  erm_pkg::q_status_t            q_status,
    output logic                          push,
    output erm_pkg::item_t                push_item
);

    // wide enough to hold SENSORS itself
    localparam int ID_CMP_W = 6;

    logic [erm_pkg::PROD_W-1:0] product;

    // us * Q2.10 scale, truncated
    assign product = erm_pkg::PROD_W'(s_echo_width) * erm_pkg::PROD_W'(speed_scale);

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

    assign push_item.req_type  = s_req_type;
    assign push_item.sensor_id = s_sensor_id;
    assign push_item.sensor_ok = ID_CMP_W'(s_sensor_id) < ID_CMP_W'(SENSORS);
    assign push_item.raw       = product[erm_pkg::PROD_W-1:erm_pkg::FRAC_W];

endmodule
`default_nettype wire

// File: hdl/erm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erm_back: per-sensor ring, median and result register
// Sequencer that takes items from the queue and updates sensor state.
// ----------------------------------------------------------------------------
module erm_back #(
    parameter int SENSORS = erm_pkg::SENSORS_DEF,
    parameter int WINDOW  = erm_pkg::WINDOW_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  erm_pkg::window_t              win,
    input  erm_pkg::item_t                head,
    input  erm_pkg::q_status_t            q_status,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [erm_pkg::DIST_W-1:0]    m_distance,
    output logic                          m_valid_res
);

    localparam int DIST_W = erm_pkg::DIST_W;
    localparam int RAW_W  = erm_pkg::RAW_W;
    localparam int IDX_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam int POS_W  = $clog2(WINDOW);
    localparam int ROW_W  = WINDOW * DIST_W;
    localparam int MID    = WINDOW / 2;

    typedef enum logic [1:0] {ST_IDLE, ST_ROW, ST_CMP, ST_RANK} state_t;

    state_t              state_reg;
    logic [IDX_W-1:0]    cur_idx_reg;
    logic [RAW_W-1:0]    cur_raw_reg;
    logic [ROW_W-1:0]    ring_mem [SENSORS];
    logic [ROW_W-1:0]    ring_rd_reg;
    logic [SENSORS-1:0]  row_valid_reg;
    logic [POS_W-1:0]    pos_reg [SENSORS];
    logic [DIST_W-1:0]   held_reg [SENSORS];
    logic [SENSORS-1:0]  fresh_reg;
    logic [DIST_W-1:0]   samp_reg [WINDOW];
    logic [WINDOW-1:0]   before_reg [WINDOW];
    logic                m_valid_reg;
    logic [DIST_W-1:0]   m_distance_reg;
    logic                m_valid_res_reg;

    logic [IDX_W+erm_pkg::SID_W-1:0] idx_wide;
    logic [IDX_W-1:0]    head_idx;
    logic                out_free;
    logic                rd_hit;
    logic [DIST_W-1:0]   raw16;
    logic                raw_in_win;
    logic [DIST_W-1:0]   held_cur;
    logic                held_in_win;
    logic [POS_W-1:0]    pos_cur;
    logic [POS_W-1:0]    pos_inc;
    logic [ROW_W-1:0]    row_old;
    logic [ROW_W-1:0]    row_next;
    logic [DIST_W-1:0]   samp_next [WINDOW];
    logic [WINDOW-1:0]   before_next [WINDOW];
    logic [DIST_W-1:0]   median;

    assign idx_wide = {{IDX_W{1'b0}}, head.sensor_id};
    assign head_idx = idx_wide[IDX_W-1:0];

    assign out_free = !m_valid_reg || m_ready;
    assign pop      = (state_reg == ST_IDLE) && !q_status.empty
                      && ((head.req_type == erm_pkg::REQ_ECHO) || out_free);
    assign rd_hit   = head.sensor_ok && fresh_reg[head_idx];

    // window checks; anything above 16 bits is out of window
    assign raw16       = cur_raw_reg[DIST_W-1:0];
    assign raw_in_win  = (cur_raw_reg[RAW_W-1:DIST_W] == '0)
                         && (raw16 >= win.min_dist) && (raw16 <= win.max_dist);
    assign held_cur    = held_reg[cur_idx_reg];
    assign held_in_win = (held_cur >= win.min_dist) && (held_cur <= win.max_dist);

    assign pos_cur = pos_reg[cur_idx_reg];
    assign pos_inc = (pos_cur == POS_W'(WINDOW - 1)) ? '0 : pos_cur + 1'b1;

    // never-written row reads as all zero
    assign row_old = row_valid_reg[cur_idx_reg] ? ring_rd_reg : '0;

    always_comb begin
        for (int k = 0; k < WINDOW; k++) begin
            samp_next[k] = (POS_W'(k) == pos_cur) ? raw16 : row_old[k*DIST_W +: DIST_W];
            row_next[k*DIST_W +: DIST_W] = samp_next[k];
        end
    end

    // before_next[i][j]: sample j sorts ahead of sample i (stable order)
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            for (int j = 0; j < WINDOW; j++) begin
                if (j < i) begin
                    before_next[i][j] = samp_reg[j] <= samp_reg[i];
                end else if (j > i) begin
                    before_next[i][j] = samp_reg[j] < samp_reg[i];
                end else begin
                    before_next[i][j] = 1'b0;
                end
            end
        end
    end

    // exactly one sample has rank MID
    always_comb begin
        median = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if ($countones(before_reg[i]) == MID) begin
                median = median | samp_reg[i];
            end
        end
    end

    // control state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            row_valid_reg <= '0;
            fresh_reg     <= '0;
            for (int s = 0; s < SENSORS; s++) begin
                pos_reg[s]  <= '0;
                held_reg[s] <= '0;
            end
        end else begin
            // a new read result replaces the one leaving this cycle
            if (pop && (head.req_type == erm_pkg::REQ_READ)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        if (head.req_type == erm_pkg::REQ_READ) begin
                            if (rd_hit) begin
                                fresh_reg[head_idx] <= 1'b0;
                            end
                        end else if (head.sensor_ok) begin
                            state_reg <= ST_ROW;
                        end
                    end
                end
                ST_ROW: begin
                    if (raw_in_win) begin
                        row_valid_reg[cur_idx_reg] <= 1'b1;
                        pos_reg[cur_idx_reg]       <= pos_inc;
                        state_reg                  <= ST_CMP;
                    end else begin
                        if (!held_in_win) begin
                            held_reg[cur_idx_reg] <= '0;
                        end
                        fresh_reg[cur_idx_reg] <= 1'b1;
                        state_reg              <= ST_IDLE;
                    end
                end
                ST_CMP: begin
                    state_reg <= ST_RANK;
                end
                ST_RANK: begin
                    held_reg[cur_idx_reg]  <= median;
                    fresh_reg[cur_idx_reg] <= 1'b1;
                    state_reg              <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload and ring memory
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_idx_reg <= head_idx;
            cur_raw_reg <= head.raw;
            ring_rd_reg <= ring_mem[head_idx];
            if (head.req_type == erm_pkg::REQ_READ) begin
                m_distance_reg  <= rd_hit ? held_reg[head_idx] : '0;
                m_valid_res_reg <= rd_hit;
            end
        end
        if ((state_reg == ST_ROW) && raw_in_win) begin
            ring_mem[cur_idx_reg] <= row_next;
            for (int k = 0; k < WINDOW; k++) begin
                samp_reg[k] <= samp_next[k];
            end
        end
        if (state_reg == ST_CMP) begin
            for (int i = 0; i < WINDOW; i++) begin
                before_reg[i] <= before_next[i];
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_distance  = m_distance_reg;
    assign m_valid_res = m_valid_res_reg;

endmodule
`default_nettype wire
